FILE: rtl/core/mm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_pkg
// shared types and constants for the fixed-point matrix multiply block
// ----------------------------------------------------------------------------
package mm_pkg;

   // element and register widths
   localparam int ELEM_W  = 32;
   localparam int CFG_W   = 4;
   localparam int INDEX_W = 3;
   // exact sum of up to fifteen full-width products
   localparam int ACC_W   = 2 * ELEM_W + CFG_W;

   // command codes
   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_LOAD_A  = 2'd0;
   localparam cmd_type CMD_LOAD_B  = 2'd1;
   localparam cmd_type CMD_COMPUTE = 2'd2;

   // configuration register indexes
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_ROWS_A    = 2'd0;
   localparam csr_index_type CSR_INNER_DIM = 2'd1;
   localparam csr_index_type CSR_COLS_B    = 2'd2;

   typedef struct packed {
      cmd_type                   cmd;
      logic [INDEX_W-1:0]        row_index;
      logic [INDEX_W-1:0]        col_index;
      logic signed [ELEM_W-1:0]  elem_value;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]        out_row;
      logic [INDEX_W-1:0]        out_col;
      logic signed [ELEM_W-1:0]  out_value;
      logic                      last_flag;
   } rsp_type;

endpackage

FILE: rtl/core/mm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module mm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/matrix_multiply_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_top
// fixed-point general matrix multiply, c = a x b, with element-wise loading
// ----------------------------------------------------------------------------
// a load item (cmd load a / load b) writes one q16.16 element into the a or b
// store; loads stream at one item per clock while no compute is in progress,
// and a write whose row or column is at or beyond MAX_DIM is dropped. a
// compute item emits every element of c in row-major order with last_flag on
// the final one. each element is an exact sum of products, rounded half
// towards plus infinity to FRAC_BITS fraction bits and saturated to 32 bits.
// dimension registers read as 1 when zero and as the smaller of MAX_DIM and
// 15 when above that. compute uses one multiply-accumulate unit fed by one
// read port on each store, one inner step per clock while the result side
// does not stall: the block stays busy through the run and the pipeline drain
// before it takes the next item, longer if the result side stalls. the final
// result may still be waiting on the rsp side when the next item is taken.
// reading a store entry that was never loaded gives an undefined element.
// ----------------------------------------------------------------------------
module matrix_multiply_top import mm_pkg::*; #(
   parameter int MAX_DIM   = 8,
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   // item input
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   // result output
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   // register writes
   input  logic               csr_wr_en,
   input  csr_index_type      csr_index,
   input  logic [CFG_W-1:0]   csr_wdata
);

   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   // largest effective dimension the 4-bit registers can reach
   localparam int DIM_CAP = (MAX_DIM < 15) ? MAX_DIM : 15;
   localparam logic [CFG_W-1:0] DIM_CAP_V = CFG_W'(DIM_CAP);
   // half an lsb of the result, zero when there are no fraction bits
   localparam logic signed [ACC_W-1:0] RND_HALF = (ACC_W'(1) << FRAC_BITS) >> 1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   // sideband that travels alongside each inner step
   typedef struct packed {
      logic               first;
      logic               last_k;
      logic               last_elem;
      logic [INDEX_W-1:0] row;
      logic [INDEX_W-1:0] col;
   } tag_type;

   // dimension registers
   logic [CFG_W-1:0] rows_a_ff, inner_dim_ff, cols_b_ff;

   // sequencer
   state_type        state_ff, state_in;
   logic [CFG_W-1:0] nr_ff, nr_in, nk_ff, nk_in, nc_ff, nc_in;
   logic [CFG_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;

   // pipeline
   logic                     s1_valid_ff, s1_valid_in;
   tag_type                  s1_tag_ff, s1_tag_in, issue_tag;
   logic                     s2_valid_ff, s2_valid_in;
   tag_type                  s2_tag_ff, s2_tag_in;
   logic signed [2*ELEM_W-1:0] prod_ff, prod_in;
   logic                     s3_done_ff, s3_done_in;
   tag_type                  s3_tag_ff, s3_tag_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     req_accept, adv, issue, wr_ok;
   logic                     a_wr_en, b_wr_en;
   logic [ADDR_W-1:0]        wr_addr, a_rd_addr, b_rd_addr;
   logic [ELEM_W-1:0]        a_rd_data, b_rd_data;
   logic signed [ACC_W-1:0]  rnd_sum, rnd_shift;
   logic [ACC_W-ELEM_W:0]    rnd_upper;
   logic signed [ELEM_W-1:0] sat_value;

   function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
      logic [CFG_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = CFG_W'(1);
      end else if (v > DIM_CAP_V) begin
         r = DIM_CAP_V;
      end
      return r;
   endfunction

   // the whole pipeline freezes while a finished result is held back
   assign adv        = !(rsp_valid_ff && rsp_stall);
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign issue      = (state_ff == ST_RUN);

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= CFG_W'(8);
         inner_dim_ff <= CFG_W'(8);
         cols_b_ff    <= CFG_W'(8);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ROWS_A:    rows_a_ff    <= csr_wdata;
            CSR_INNER_DIM: inner_dim_ff <= csr_wdata;
            CSR_COLS_B:    cols_b_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- loads
   // stores hold entries at row*MAX_DIM+col; out-of-range writes are dropped
   assign wr_ok   = (int'(req_data.row_index) < MAX_DIM) &&
                    (int'(req_data.col_index) < MAX_DIM);
   assign wr_addr = ADDR_W'(int'(req_data.row_index) * MAX_DIM +
                            int'(req_data.col_index));
   assign a_wr_en = req_accept && (req_data.cmd == CMD_LOAD_A) && wr_ok;
   assign b_wr_en = req_accept && (req_data.cmd == CMD_LOAD_B) && wr_ok;

   // compute reads a[i][k] and b[k][j]; loads are locked out while it runs
   assign a_rd_addr = ADDR_W'(int'(i_ff) * MAX_DIM + int'(k_ff));
   assign b_rd_addr = ADDR_W'(int'(k_ff) * MAX_DIM + int'(j_ff));

   mm_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (DEPTH)
   ) u_a_store (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.elem_value),
      .rd_en   (adv),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   mm_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (DEPTH)
   ) u_b_store (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.elem_value),
      .rd_en   (adv),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      nr_in    = nr_ff;
      nk_in    = nk_ff;
      nc_in    = nc_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_data.cmd == CMD_COMPUTE)) begin
               // dimensions are frozen for the whole run
               nr_in    = eff_dim(rows_a_ff);
               nk_in    = eff_dim(inner_dim_ff);
               nc_in    = eff_dim(cols_b_ff);
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (adv) begin
               // inner index fastest, then column, then row
               if (k_ff == nk_ff - CFG_W'(1)) begin
                  k_in = '0;
                  if (j_ff == nc_ff - CFG_W'(1)) begin
                     j_in = '0;
                     if (i_ff == nr_ff - CFG_W'(1)) begin
                        state_in = ST_DRAIN;
                     end else begin
                        i_in = i_ff + CFG_W'(1);
                     end
                  end else begin
                     j_in = j_ff + CFG_W'(1);
                  end
               end else begin
                  k_in = k_ff + CFG_W'(1);
               end
            end
         end
         ST_DRAIN: begin
            // wait for the last reads and products to leave the pipeline
            if (!s1_valid_ff && !s2_valid_ff && !s3_done_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      issue_tag.first     = (k_ff == '0);
      issue_tag.last_k    = (k_ff == nk_ff - CFG_W'(1));
      issue_tag.last_elem = (i_ff == nr_ff - CFG_W'(1)) && (j_ff == nc_ff - CFG_W'(1));
      issue_tag.row       = i_ff[INDEX_W-1:0];
      issue_tag.col       = j_ff[INDEX_W-1:0];
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      // stage 1: store read data
      s1_valid_in = adv ? issue : s1_valid_ff;
      s1_tag_in   = adv ? issue_tag : s1_tag_ff;
      // stage 2: product
      s2_valid_in = adv ? s1_valid_ff : s2_valid_ff;
      s2_tag_in   = adv ? s1_tag_ff : s2_tag_ff;
      prod_in     = adv ? ($signed(a_rd_data) * $signed(b_rd_data)) : prod_ff;
      // stage 3: accumulate, restarting on the first inner step
      s3_done_in  = adv ? (s2_valid_ff && s2_tag_ff.last_k) : s3_done_ff;
      s3_tag_in   = adv ? s2_tag_ff : s3_tag_ff;
      acc_in      = acc_ff;
      if (adv && s2_valid_ff) begin
         if (s2_tag_ff.first) begin
            acc_in = ACC_W'(prod_ff);
         end else begin
            acc_in = acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   // round half up, then clamp to the 32-bit range
   always_comb begin
      rnd_sum   = acc_ff + RND_HALF;
      rnd_shift = rnd_sum >>> FRAC_BITS;
      rnd_upper = rnd_shift[ACC_W-1:ELEM_W-1];
      if ((&rnd_upper) || !(|rnd_upper)) begin
         sat_value = rnd_shift[ELEM_W-1:0];
      end else if (rnd_shift[ACC_W-1]) begin
         sat_value = {1'b1, {(ELEM_W-1){1'b0}}};
      end else begin
         sat_value = {1'b0, {(ELEM_W-1){1'b1}}};
      end
   end

   // stage 4: output register
   always_comb begin
      rsp_valid_in = adv ? s3_done_ff : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (adv && s3_done_ff) begin
         rsp_data_in.out_row   = s3_tag_ff.row;
         rsp_data_in.out_col   = s3_tag_ff.col;
         rsp_data_in.out_value = sat_value;
         rsp_data_in.last_flag = s3_tag_ff.last_elem;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_done_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_done_ff   <= s3_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      nr_ff       <= nr_in;
      nk_ff       <= nk_in;
      nc_ff       <= nc_in;
      s1_tag_ff   <= s1_tag_in;
      s2_tag_ff   <= s2_tag_in;
      prod_ff     <= prod_in;
      s3_tag_ff   <= s3_tag_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // stores are never written while a run is reading them
   assert property (@(posedge clock) disable iff (reset)
      (a_wr_en || b_wr_en) |-> (state_ff == ST_IDLE))
      else $error("store written during a compute run");

   // run counters stay inside the frozen dimensions
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> ((i_ff < nr_ff) && (j_ff < nc_ff) && (k_ff < nk_ff)))
      else $error("run counter out of range");

   // nothing is left in flight once the block goes idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!s1_valid_ff && !s2_valid_ff && !s3_done_ff))
      else $error("pipeline busy while idle");

   // a held result freezes the accumulator
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(acc_ff))
      else $error("accumulator moved while output stalled");
`endif

endmodule
